@@ design/lfu_pkg.sv @@
// lfu_pkg: shared types and constants for the lfu cache table
// holds the request/response payload structs, command and state codes
// no dependencies
package lfu_pkg;

   localparam int KEY_W   = 32;
   localparam int COUNT_W = 16;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
   localparam logic [COUNT_W-1:0] COUNT_INIT = 16'd1;
   localparam logic [KEY_W-1:0]   MISS_VALUE = 32'hFFFF_FFFF;

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      cmd_type            command;
      logic signed [31:0] lookup_key;
      logic signed [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
      logic signed [31:0] evicted_key;
   } rsp_type;

   typedef struct packed {
      logic found;
      logic victim_any;
      logic free_any;
   } scan_flags_type;

endpackage

@@ design/lfu_scan_unit.sv @@
// lfu_scan_unit: one-entry-per-cycle (while cmp_en is high) compare unit for the cache scan
// finds the first key match, the lfu/lru victim and the first free slot
// depends on lfu_pkg
module lfu_scan_unit
   import lfu_pkg::*;
#(
   parameter int IW = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmp_en,
   input  logic                cmp_first,
   input  logic [IW-1:0]       cmp_idx,
   input  logic                ent_valid,
   input  logic [KEY_W-1:0]    ent_key,
   input  logic [KEY_W-1:0]    ent_value,
   input  logic [COUNT_W-1:0]  ent_count,
   input  logic [IW-1:0]       ent_rank,
   input  logic [KEY_W-1:0]    lookup_key,
   output scan_flags_type      flags,
   output logic [IW-1:0]       found_idx,
   output logic [COUNT_W-1:0]  found_count,
   output logic [IW-1:0]       found_rank,
   output logic [KEY_W-1:0]    found_value,
   output logic [IW-1:0]       best_idx,
   output logic [IW-1:0]       best_rank,
   output logic [KEY_W-1:0]    best_key,
   output logic [IW-1:0]       free_idx
);

   scan_flags_type      flags_ff, flags_in, base;
   logic [IW-1:0]       found_idx_ff, found_rank_ff, best_idx_ff, best_rank_ff, free_idx_ff;
   logic [COUNT_W-1:0]  found_count_ff, best_count_ff;
   logic [KEY_W-1:0]    found_value_ff, best_key_ff;
   logic                is_match, is_better, is_free;

   always_comb begin
      base = cmp_first ? '0 : flags_ff;
      is_match  = ent_valid && (ent_key == lookup_key) && !base.found;
      // lower count wins, equal counts go to the older entry
      is_better = ent_valid && (!base.victim_any || (ent_count < best_count_ff) ||
                  ((ent_count == best_count_ff) && (ent_rank > best_rank_ff)));
      is_free   = !ent_valid && !base.free_any;
      flags_in.found      = base.found | is_match;
      flags_in.victim_any = base.victim_any | is_better;
      flags_in.free_any   = base.free_any | is_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (cmp_en) begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_en && is_match) begin
         found_idx_ff   <= cmp_idx;
         found_count_ff <= ent_count;
         found_rank_ff  <= ent_rank;
         found_value_ff <= ent_value;
      end
      if (cmp_en && is_better) begin
         best_idx_ff   <= cmp_idx;
         best_count_ff <= ent_count;
         best_rank_ff  <= ent_rank;
         best_key_ff   <= ent_key;
      end
      if (cmp_en && is_free) begin
         free_idx_ff <= cmp_idx;
      end
   end

   assign flags       = flags_ff;
   assign found_idx   = found_idx_ff;
   assign found_count = found_count_ff;
   assign found_rank  = found_rank_ff;
   assign found_value = found_value_ff;
   assign best_idx    = best_idx_ff;
   assign best_rank   = best_rank_ff;
   assign best_key    = best_key_ff;
   assign free_idx    = free_idx_ff;

endmodule

@@ design/lfu_cache_table.sv @@
// lfu_cache_table: key/value cache, least-frequently-used replacement, lru tie break
// one request at a time: the single scan over all entries through the shared compare
// unit is followed by a drain and a write-back state; the next request is taken only
// after the write-back, which waits while an earlier response is not yet taken
// reset: synchronous, clears the valid bits, occupancy and sets capacity to 16
// depends on lfu_pkg and lfu_scan_unit
module lfu_cache_table
   import lfu_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OW   = $clog2(MAX_ENTRIES + 1);
   localparam int CMPW = (OW > CAP_W) ? OW : CAP_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

   state_type            state_ff, state_in;
   logic [CAP_W-1:0]     cap_ff;
   logic [OW-1:0]        occ_ff, occ_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [IW-1:0]        rank_ff [MAX_ENTRIES];
   logic [IW-1:0]        rank_in [MAX_ENTRIES];
   logic [IW-1:0]        scan_ptr_ff, scan_ptr_in;
   logic                 cmp_en_ff;
   logic [IW-1:0]        cmp_idx_ff;
   req_type              req_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic [KEY_W-1:0]     key_mem [MAX_ENTRIES];
   logic [KEY_W-1:0]     val_mem [MAX_ENTRIES];
   logic [COUNT_W-1:0]   cnt_mem [MAX_ENTRIES];
   logic [KEY_W-1:0]     rd_key_ff, rd_val_ff;
   logic [COUNT_W-1:0]   rd_cnt_ff;

   scan_flags_type       flags;
   logic [IW-1:0]        found_idx, found_rank, best_idx, best_rank, free_idx;
   logic [COUNT_W-1:0]   found_count;
   logic [KEY_W-1:0]     found_value, best_key;

   logic                 scan_run, in_commit, commit_go;
   logic [CMPW-1:0]      cap_wide, cap_eff, occ_wide;
   logic                 cap_zero, table_full, is_put;
   logic                 do_touch, do_val_wr, do_evict, do_fill, do_insert;
   logic [IW-1:0]        slot;
   logic                 key_we, val_we, cnt_we;
   logic [IW-1:0]        val_wa, cnt_wa;
   logic [KEY_W-1:0]     val_wd;
   logic [COUNT_W-1:0]   cnt_wd, touch_count;

   // fsm next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCAN;
         ST_SCAN:   if (scan_ptr_ff == LAST_IDX) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_COMMIT;
         ST_COMMIT: if (commit_go) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready = 1'b0;
      scan_run  = 1'b0;
      in_commit = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   scan_run  = 1'b1;
         ST_DRAIN:  ;
         ST_COMMIT: in_commit = 1'b1;
         default:   ;
      endcase
   end

   assign commit_go   = in_commit && (!rsp_valid_ff || rsp_ready);
   assign scan_ptr_in = scan_run ? scan_ptr_ff + IW'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ptr_ff  <= '0;
         cmp_en_ff    <= 1'b0;
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_ptr_ff <= scan_ptr_in;
         cmp_en_ff   <= scan_run;
         if (csr_valid) cap_ff <= csr_data;
         if (commit_go) begin
            occ_ff   <= occ_in;
            valid_ff <= valid_in;
         end
         if (commit_go) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_ptr_ff;
      if (req_valid && req_ready) req_ff <= req_data;
      if (commit_go) rsp_ff <= rsp_in;
      if (commit_go) rank_ff <= rank_in;
   end

   // entry stores, one read at the scan pointer and one write per cycle
   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[scan_ptr_ff];
      rd_val_ff <= val_mem[scan_ptr_ff];
      rd_cnt_ff <= cnt_mem[scan_ptr_ff];
      if (key_we) key_mem[slot] <= req_ff.lookup_key;
      if (val_we) val_mem[val_wa] <= val_wd;
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
   end

   lfu_scan_unit #(.IW(IW)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .cmp_en      (cmp_en_ff),
      .cmp_first   (cmp_idx_ff == '0),
      .cmp_idx     (cmp_idx_ff),
      .ent_valid   (valid_ff[cmp_idx_ff]),
      .ent_key     (rd_key_ff),
      .ent_value   (rd_val_ff),
      .ent_count   (rd_cnt_ff),
      .ent_rank    (rank_ff[cmp_idx_ff]),
      .lookup_key  (req_ff.lookup_key),
      .flags       (flags),
      .found_idx   (found_idx),
      .found_count (found_count),
      .found_rank  (found_rank),
      .found_value (found_value),
      .best_idx    (best_idx),
      .best_rank   (best_rank),
      .best_key    (best_key),
      .free_idx    (free_idx)
   );

   // write-back decisions
   always_comb begin
      cap_wide   = CMPW'(cap_ff);
      cap_eff    = (cap_wide > CMPW'(MAX_ENTRIES)) ? CMPW'(MAX_ENTRIES) : cap_wide;
      occ_wide   = CMPW'(occ_ff);
      cap_zero   = (cap_eff == '0);
      table_full = (occ_wide >= cap_eff);
      is_put     = (req_ff.command == CMD_PUT);
      do_touch   = flags.found && (!is_put || !cap_zero);
      do_val_wr  = flags.found && is_put && !cap_zero;
      do_evict   = !flags.found && is_put && !cap_zero && table_full && flags.victim_any;
      do_fill    = !flags.found && is_put && !cap_zero && !do_evict && flags.free_any;
      do_insert  = do_evict || do_fill;
      slot       = do_evict ? best_idx : free_idx;
      touch_count = (found_count == COUNT_MAX) ? found_count : found_count + COUNT_W'(1);

      key_we = commit_go && do_insert;
      val_we = commit_go && (do_insert || do_val_wr);
      val_wa = do_insert ? slot : found_idx;
      val_wd = req_ff.write_value;
      cnt_we = commit_go && (do_insert || do_touch);
      cnt_wa = do_insert ? slot : found_idx;
      cnt_wd = do_insert ? COUNT_INIT : touch_count;

      valid_in = valid_ff;
      occ_in   = occ_ff;
      if (do_fill) begin
         valid_in[slot] = 1'b1;
         occ_in         = occ_ff + OW'(1);
      end

      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (do_touch) begin
            if (IW'(i) == found_idx) rank_in[i] = '0;
            else if (valid_ff[i] && (rank_ff[i] < found_rank)) rank_in[i] = rank_ff[i] + IW'(1);
         end else if (do_evict) begin
            // entries younger than the victim age by one; older ones close the gap then age, so keep their rank
            if (IW'(i) == slot) rank_in[i] = '0;
            else if (valid_ff[i] && !(rank_ff[i] > best_rank)) rank_in[i] = rank_ff[i] + IW'(1);
         end else if (do_fill) begin
            if (IW'(i) == slot) rank_in[i] = '0;
            else if (valid_ff[i]) rank_in[i] = rank_ff[i] + IW'(1);
         end
      end

      rsp_in.hit         = flags.found;
      rsp_in.read_value  = is_put ? '0 : (flags.found ? found_value : MISS_VALUE);
      rsp_in.evicted     = do_evict;
      rsp_in.evicted_key = do_evict ? best_key : '0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy out of step with valid bits");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      int'(occ_ff) <= MAX_ENTRIES)
      else $error("occupancy above table size");

   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      commit_go |=> rsp_valid)
      else $error("write-back did not present a response");

   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !req_ready)
      else $error("request taken during scan");

endmodule

@@ tb/sv/tb_lfu_cache_table.sv @@
// tb_lfu_cache_table: self-checking testbench for the lfu cache table
// predicts every response with a behavioral cache model and compares field by field
// depends on lfu_pkg and lfu_cache_table
module tb_lfu_cache_table;
   import lfu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES = 16;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CAP_W-1:0] csr_data = '0;

   lfu_cache_table #(.MAX_ENTRIES(ENTRIES)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // cache model state
   logic              slot_valid [ENTRIES];
   logic [31:0]       slot_key   [ENTRIES];
   logic [31:0]       slot_value [ENTRIES];
   logic [COUNT_W-1:0] slot_count [ENTRIES];
   int unsigned       slot_rank  [ENTRIES];
   int unsigned       occupancy;
   logic [CAP_W-1:0]  capacity;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int mismatches = 0;
   int unsigned cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic hold_sends = 1'b0;
   logic req_accepted = 1'b0;

   function automatic void cache_clear();
      for (int i = 0; i < ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i] = '0;
         slot_value[i] = '0;
         slot_count[i] = '0;
         slot_rank[i] = 0;
      end
      occupancy = 0;
      capacity = CAP_RESET;
   endfunction

   function automatic void make_recent(int idx);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && slot_rank[i] < slot_rank[idx]) slot_rank[i]++;
      slot_rank[idx] = 0;
      if (slot_count[idx] != COUNT_MAX) slot_count[idx]++;
   endfunction

   function automatic rsp_type cache_access(req_type rq);
      rsp_type r = '0;
      int found = -1;
      int best = -1;
      int slot = -1;
      int unsigned cap;
      cap = (capacity > ENTRIES) ? ENTRIES : capacity;
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && slot_valid[i] && slot_key[i] == rq.lookup_key) found = i;
      r.hit = (found >= 0);
      if (rq.command == CMD_GET) begin
         if (found >= 0) begin
            make_recent(found);
            r.read_value = slot_value[found];
         end else begin
            r.read_value = MISS_VALUE;
         end
      end else if (cap != 0) begin
         if (found >= 0) begin
            slot_value[found] = rq.write_value;
            make_recent(found);
         end else begin
            if (occupancy >= cap) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (slot_valid[i] && (best < 0 || slot_count[i] < slot_count[best] ||
                      (slot_count[i] == slot_count[best] &&
                       slot_rank[i] > slot_rank[best]))) best = i;
               if (best >= 0) begin
                  r.evicted = 1'b1;
                  r.evicted_key = slot_key[best];
                  slot_valid[best] = 1'b0;
                  for (int i = 0; i < ENTRIES; i++)
                     if (slot_valid[i] && slot_rank[i] > slot_rank[best]) slot_rank[i]--;
                  if (occupancy > 0) occupancy--;
                  slot = best;
               end
            end
            if (slot < 0)
               for (int i = 0; i < ENTRIES; i++)
                  if (slot < 0 && !slot_valid[i]) slot = i;
            if (slot >= 0) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (slot_valid[i]) slot_rank[i]++;
               slot_valid[slot] = 1'b1;
               slot_key[slot] = rq.lookup_key;
               slot_value[slot] = rq.write_value;
               slot_count[slot] = COUNT_INIT;
               slot_rank[slot] = 0;
               occupancy++;
            end
         end
      end
      return r;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         // hold until transfer
      end else if (pending_reqs.size() > 0 && !hold_sends &&
                   $urandom_range(99) >= send_idle_pct) begin
         req_valid <= 1'b1;
         req_data <= pending_reqs.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: prediction on request transfer, check on response transfer
   always @(posedge clock) begin
      rsp_type exp_r;
      cycles <= cycles + 1;
      req_accepted <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) expected_rsps.push_back(cache_access(req_data));
         if (csr_valid && csr_ready) capacity = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               exp_r = expected_rsps.pop_front();
               if (rsp_data.hit !== exp_r.hit || rsp_data.read_value !== exp_r.read_value ||
                   rsp_data.evicted !== exp_r.evicted ||
                   rsp_data.evicted_key !== exp_r.evicted_key) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", exp_r, rsp_data);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void queue_req(cmd_type c, logic [31:0] k, logic [31:0] v);
      req_type rq;
      rq.command = c;
      rq.lookup_key = k;
      rq.write_value = v;
      pending_reqs.push_back(rq);
   endfunction

   // keys mostly come from a small pool so hits and evictions are frequent
   function automatic void queue_random(int n, int pool);
      for (int i = 0; i < n; i++) begin
         logic [31:0] k;
         if ($urandom_range(9) == 0) k = $urandom();
         else k = 32'h8000_0000 ^ ($urandom_range(pool - 1) * 32'h0101_0101);
         queue_req($urandom_range(1) ? CMD_PUT : CMD_GET, k, $urandom());
      end
   endfunction

   initial begin
      cache_clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, misses, hits, eviction and tie break
      queue_req(CMD_GET, 32'h8000_0000, 32'h0);
      queue_req(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_req(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_req(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(CMD_PUT, 32'h0, 32'h0);
      queue_req(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_req(CMD_GET, 32'hFFFF_FFFF, 32'h0);
      queue_req(CMD_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
      queue_req(CMD_GET, 32'h7FFF_FFFF, 32'h0);
      queue_req(CMD_GET, 32'h1, 32'h0);
      write_capacity(5'd0);
      // puts ignored while capacity is zero
      queue_req(CMD_PUT, 32'h5, 32'h5);
      queue_req(CMD_PUT, 32'h0, 32'hAAAA_5555);
      queue_req(CMD_GET, 32'h0, 32'h0);
      queue_req(CMD_GET, 32'h5, 32'h0);
      // capacity lowered below occupancy, then evictions
      write_capacity(5'd2);
      queue_req(CMD_PUT, 32'h10, 32'h1);
      queue_req(CMD_PUT, 32'h11, 32'h2);
      queue_req(CMD_GET, 32'h10, 32'h0);
      queue_req(CMD_PUT, 32'h12, 32'h3);
      queue_req(CMD_PUT, 32'h13, 32'h4);
      write_capacity(5'd31);
      for (int i = 0; i < 18; i++) queue_req(CMD_PUT, 32'h100 + i, i);

      // random phases across capacity settings and idling mixes
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 59; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 59; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         case (ph)
            0: write_capacity(5'd16);
            2: write_capacity(5'd1);
            4: write_capacity(5'd17);
            5: write_capacity(5'd0);
            6: write_capacity(5'd31);
            default: write_capacity(5'($urandom_range(2, 15)));
         endcase
         queue_random(60, (ph % 2) ? 24 : 12);
         if (ph == 3) begin
            // stop sending until all responses are back
            while (pending_reqs.size() > 40) @(posedge clock);
            hold_sends = 1'b1;
            while (req_valid || expected_rsps.size() > 0) @(posedge clock);
            hold_sends = 1'b0;
         end
      end

      // push one hot key toward count saturation is too slow; exercise repeats instead
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < 40; i++) queue_req(CMD_GET, 32'h8000_0000, 32'h0);

      wait_drained();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
